// ===== rtl/irpd_pkg.sv =====
// Shared types, constants and helpers for the IR pulse-distance transmitter.
// No dependencies; used by irpd_seq and ir_pulse_distance_transmitter.
`timescale 1ns / 1ps

package irpd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_BURST = 3'd0;
    localparam logic [2:0] REG_START_SPACE = 3'd1;
    localparam logic [2:0] REG_MARK        = 3'd2;
    localparam logic [2:0] REG_ZERO_SPACE  = 3'd3;
    localparam logic [2:0] REG_ONE_SPACE   = 3'd4;
    localparam logic [2:0] REG_STOP_BURST  = 3'd5;
    localparam logic [2:0] REG_DATA_BITS   = 3'd6;

    // Frame phase codes.
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_START_SPACE = 3'd1;
    localparam logic [2:0] PH_MARK        = 3'd2;
    localparam logic [2:0] PH_BIT_SPACE   = 3'd3;
    localparam logic [2:0] PH_STOP        = 3'd4;
    localparam logic [2:0] PH_GAP         = 3'd5;

    // Request codes on the input channel.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam int          US_W       = 16;
    localparam int          COUNT_W    = 18;
    localparam int          BITS_W     = 6;
    localparam int          CODE_W     = 32;
    localparam logic [17:0] GAP_COUNTS = 18'd60000;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_START_BURST = 16'd9000;
    localparam logic [15:0] RST_START_SPACE = 16'd4500;
    localparam logic [15:0] RST_MARK        = 16'd560;
    localparam logic [15:0] RST_ZERO_SPACE  = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE   = 16'd1690;
    localparam logic [15:0] RST_STOP_BURST  = 16'd560;
    localparam logic [5:0]  RST_DATA_BITS   = 6'd32;

    typedef struct packed {
        logic [US_W-1:0]   start_burst_us;
        logic [US_W-1:0]   start_space_us;
        logic [US_W-1:0]   mark_us;
        logic [US_W-1:0]   zero_space_us;
        logic [US_W-1:0]   one_space_us;
        logic [US_W-1:0]   stop_burst_us;
        logic [BITS_W-1:0] data_bits;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               carrier_on;
        logic [COUNT_W-1:0] duration_counts;
        logic               frame_done;
    } seg_t;

    // Four timer counts per microsecond.
    function automatic logic [COUNT_W-1:0] us_to_counts(input logic [US_W-1:0] us);
        us_to_counts = {us, 2'b00};
    endfunction

endpackage

// ===== rtl/irpd_seq.sv =====
// Frame sequencer: phase, pending flag, code shifter and bit counter.
// Produces the segment, if any, for each accepted beat. Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        req_type,
    input  logic [irpd_pkg::CODE_W-1:0] code_word,
    input  irpd_pkg::cfg_t              cfg,
    output irpd_pkg::seg_t              seg
);

    logic [2:0]                  phase_reg, phase_next;
    logic                        pending_reg, pending_next;
    logic [irpd_pkg::CODE_W-1:0] code_reg, code_next;
    logic [irpd_pkg::BITS_W-1:0] bits_reg, bits_next;
    logic [irpd_pkg::BITS_W-1:0] bits_inc;

    assign bits_inc = bits_reg + irpd_pkg::BITS_W'(1);

    // Segment selection and next state for one beat.
    always_comb begin
        phase_next          = phase_reg;
        pending_next        = pending_reg;
        code_next           = code_reg;
        bits_next           = bits_reg;
        seg.valid           = 1'b0;
        seg.carrier_on      = 1'b0;
        seg.duration_counts = '0;
        seg.frame_done      = 1'b0;
        if (req_type == irpd_pkg::REQ_START) begin
            // A start request is only taken between frames.
            if (phase_reg == irpd_pkg::PH_IDLE) begin
                code_next    = code_word;
                pending_next = 1'b1;
                bits_next    = '0;
            end
        end else begin
            case (phase_reg)
                irpd_pkg::PH_START_SPACE: begin
                    seg.valid           = 1'b1;
                    seg.duration_counts = irpd_pkg::us_to_counts(cfg.start_space_us);
                    phase_next          = irpd_pkg::PH_MARK;
                end
                irpd_pkg::PH_MARK: begin
                    seg.valid           = 1'b1;
                    seg.carrier_on      = 1'b1;
                    seg.duration_counts = irpd_pkg::us_to_counts(cfg.mark_us);
                    phase_next          = irpd_pkg::PH_BIT_SPACE;
                end
                irpd_pkg::PH_BIT_SPACE: begin
                    seg.valid           = 1'b1;
                    seg.duration_counts = irpd_pkg::us_to_counts(
                        code_reg[irpd_pkg::CODE_W-1] ? cfg.one_space_us : cfg.zero_space_us);
                    code_next           = {code_reg[irpd_pkg::CODE_W-2:0], 1'b0};
                    bits_next           = bits_inc;
                    // Stop once the count reaches the limit; a wrapped count also stops.
                    if (bits_inc >= cfg.data_bits || bits_inc == '0) begin
                        phase_next = irpd_pkg::PH_STOP;
                    end else begin
                        phase_next = irpd_pkg::PH_MARK;
                    end
                end
                irpd_pkg::PH_STOP: begin
                    seg.valid           = 1'b1;
                    seg.carrier_on      = 1'b1;
                    seg.duration_counts = irpd_pkg::us_to_counts(cfg.stop_burst_us);
                    phase_next          = irpd_pkg::PH_GAP;
                end
                irpd_pkg::PH_GAP: begin
                    seg.valid           = 1'b1;
                    seg.duration_counts = irpd_pkg::GAP_COUNTS;
                    seg.frame_done      = 1'b1;
                    phase_next          = irpd_pkg::PH_IDLE;
                    pending_next        = 1'b0;
                    bits_next           = '0;
                end
                default: begin
                    // Idle: a tick opens the frame only if a request is pending.
                    if (pending_reg) begin
                        seg.valid           = 1'b1;
                        seg.carrier_on      = 1'b1;
                        seg.duration_counts = irpd_pkg::us_to_counts(cfg.start_burst_us);
                        phase_next          = irpd_pkg::PH_START_SPACE;
                    end else begin
                        phase_next = irpd_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    // State registers advance on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= irpd_pkg::PH_IDLE;
            pending_reg <= 1'b0;
            code_reg    <= '0;
            bits_reg    <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            code_reg    <= code_next;
            bits_reg    <= bits_next;
        end
    end

endmodule

// ===== rtl/ir_pulse_distance_transmitter.sv =====
// IR pulse-distance transmitter: the segment of an accepted tick beat is registered
// and shown on m_ the next cycle; throughput is one beat per cycle while s_ready is high.
// Input and output are parted by the result register, which is refilled in the
// same cycle it is taken, so s_ready drops only while a result waits unaccepted.
// Synchronous active-low reset clears the sequencer, the result valid flag and
// loads the default configuration registers. Depends on irpd_pkg and irpd_seq.
`timescale 1ns / 1ps

module ir_pulse_distance_transmitter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [irpd_pkg::US_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [irpd_pkg::CODE_W-1:0]    s_code_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_carrier_on,
    output logic [irpd_pkg::COUNT_W-1:0]   m_duration_counts,
    output logic                           m_frame_done
);

    irpd_pkg::cfg_t cfg_reg;
    irpd_pkg::seg_t seg;
    logic           step;
    logic           m_valid_reg, m_valid_next;
    logic           carrier_reg;
    logic [irpd_pkg::COUNT_W-1:0] duration_reg;
    logic           done_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_burst_us <= irpd_pkg::RST_START_BURST;
            cfg_reg.start_space_us <= irpd_pkg::RST_START_SPACE;
            cfg_reg.mark_us        <= irpd_pkg::RST_MARK;
            cfg_reg.zero_space_us  <= irpd_pkg::RST_ZERO_SPACE;
            cfg_reg.one_space_us   <= irpd_pkg::RST_ONE_SPACE;
            cfg_reg.stop_burst_us  <= irpd_pkg::RST_STOP_BURST;
            cfg_reg.data_bits      <= irpd_pkg::RST_DATA_BITS;
        end else if (cfg_we) begin
            case (cfg_index)
                irpd_pkg::REG_START_BURST: cfg_reg.start_burst_us <= cfg_wdata;
                irpd_pkg::REG_START_SPACE: cfg_reg.start_space_us <= cfg_wdata;
                irpd_pkg::REG_MARK:        cfg_reg.mark_us        <= cfg_wdata;
                irpd_pkg::REG_ZERO_SPACE:  cfg_reg.zero_space_us  <= cfg_wdata;
                irpd_pkg::REG_ONE_SPACE:   cfg_reg.one_space_us   <= cfg_wdata;
                irpd_pkg::REG_STOP_BURST:  cfg_reg.stop_burst_us  <= cfg_wdata;
                irpd_pkg::REG_DATA_BITS:
                    cfg_reg.data_bits <= cfg_wdata[irpd_pkg::BITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Accept a new beat whenever the result register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    irpd_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .req_type  (s_req_type),
        .code_word (s_code_word),
        .cfg       (cfg_reg),
        .seg       (seg)
    );

    // Result register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step && seg.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded with each produced segment.
    always_ff @(posedge aclk) begin
        if (step && seg.valid) begin
            carrier_reg  <= seg.carrier_on;
            duration_reg <= seg.duration_counts;
            done_reg     <= seg.frame_done;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_carrier_on      = carrier_reg;
    assign m_duration_counts = duration_reg;
    assign m_frame_done      = done_reg;

endmodule
